FILE: hdl/pdpr_pkg.sv
// ----------------------------------------------------------------------------
// PWM dither pattern regulator package
// Shared types, constants and the dither mask table.
// ----------------------------------------------------------------------------
package pdpr_pkg;

   localparam int unsigned PATTERN_LEN = 16;
   localparam int unsigned SLOT_W      = $clog2(PATTERN_LEN);
   localparam int unsigned VALUE_W     = 12;
   localparam int unsigned BASE_W      = 8;
   localparam int unsigned DITHER_W    = 4;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VALUE_W-1:0]  TARGET_MAX = 12'h0FF0;
   localparam logic [BASE_W-1:0]   BASE_MAX   = 8'hFF;
   localparam logic [DITHER_W-1:0] DITHER_MAX = 4'hF;
   localparam logic [SLOT_W-1:0]   SLOT_LAST  = SLOT_W'(PATTERN_LEN - 1);

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_MEASURE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [BASE_W-1:0]      base;
      logic [PATTERN_LEN-1:0] row;
      logic                   adjusted;
   } pattern_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [PATTERN_LEN-1:0] dither_row(input logic [DITHER_W-1:0] level);
      logic [PATTERN_LEN-1:0] row;
      case (level)
         4'd0:    row = 16'h0000;
         4'd1:    row = 16'h0001;
         4'd2:    row = 16'h0101;
         4'd3:    row = 16'h0421;
         4'd4:    row = 16'h1111;
         4'd5:    row = 16'h1249;
         4'd6:    row = 16'h2525;
         4'd7:    row = 16'h2A55;
         4'd8:    row = 16'h5555;
         4'd9:    row = 16'hD5AA;
         4'd10:   row = 16'hDADA;
         4'd11:   row = 16'hEDB6;
         4'd12:   row = 16'hEEEE;
         4'd13:   row = 16'hFBDE;
         4'd14:   row = 16'hFEFE;
         4'd15:   row = 16'hFFFE;
         default: row = 16'h0000;
      endcase
      return row;
   endfunction

endpackage

FILE: hdl/pdpr_front.sv
// ----------------------------------------------------------------------------
// PWM dither pattern regulator front end
// Accepts load and measurement words, updates the setpoint, queues a pattern.
// ----------------------------------------------------------------------------
module pdpr_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [pdpr_pkg::VALUE_W-1:0]           req_value,
   input  pdpr_pkg::queue_status_type             q_status,
   output logic                                   push,
   output pdpr_pkg::pattern_desc_type             push_desc
);

   logic [pdpr_pkg::VALUE_W-1:0]  target_ff, target_in;
   logic [pdpr_pkg::BASE_W-1:0]   base_ff, base_in;
   logic [pdpr_pkg::DITHER_W-1:0] dither_ff, dither_in;
   logic [pdpr_pkg::VALUE_W-1:0]  sat_value;
   logic                          adjusted;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      target_in = target_ff;
      base_in   = base_ff;
      dither_in = dither_ff;
      adjusted  = 1'b0;
      sat_value = (req_value > pdpr_pkg::TARGET_MAX) ? pdpr_pkg::TARGET_MAX : req_value;
      if (pdpr_pkg::opcode_type'(req_opcode) == pdpr_pkg::OP_LOAD) begin
         target_in = sat_value;
         dither_in = sat_value[pdpr_pkg::DITHER_W-1:0];
         base_in   = sat_value[pdpr_pkg::VALUE_W-1:pdpr_pkg::DITHER_W];
      end else if (target_ff > req_value) begin
         adjusted = 1'b1;
         if (base_ff < pdpr_pkg::BASE_MAX) begin
            if (dither_ff == pdpr_pkg::DITHER_MAX) begin
               dither_in = '0;
               base_in   = base_ff + 1'b1;
            end else begin
               dither_in = dither_ff + 1'b1;
            end
         end
      end else if (target_ff < req_value) begin
         adjusted = 1'b1;
         if (dither_ff == '0) begin
            if (base_ff != '0) begin
               dither_in = pdpr_pkg::DITHER_MAX;
               base_in   = base_ff - 1'b1;
            end
         end else begin
            dither_in = dither_ff - 1'b1;
         end
      end
      push_desc.base     = base_in;
      push_desc.row      = pdpr_pkg::dither_row(dither_in);
      push_desc.adjusted = adjusted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         base_ff   <= '0;
         dither_ff <= '0;
      end else if (push) begin
         target_ff <= target_in;
         base_ff   <= base_in;
         dither_ff <= dither_in;
      end
   end

endmodule

FILE: hdl/pdpr_queue.sv
// ----------------------------------------------------------------------------
// PWM dither pattern regulator queue
// Short first-in first-out buffer of pattern descriptors.
// ----------------------------------------------------------------------------
module pdpr_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  pdpr_pkg::pattern_desc_type  push_desc,
   input  logic                        pop,
   output pdpr_pkg::pattern_desc_type  head_desc,
   output pdpr_pkg::queue_status_type  q_status
);

   pdpr_pkg::pattern_desc_type        entry_ff [pdpr_pkg::QUEUE_DEPTH];
   logic [pdpr_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pdpr_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pdpr_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign q_status.full  = (count_ff == pdpr_pkg::QCNT_W'(pdpr_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_desc      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == pdpr_pkg::QPTR_W'(pdpr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == pdpr_pkg::QPTR_W'(pdpr_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: hdl/pdpr_back.sv
// ----------------------------------------------------------------------------
// PWM dither pattern regulator back end
// Expands a queued descriptor into sixteen registered compare words.
// ----------------------------------------------------------------------------
module pdpr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  pdpr_pkg::queue_status_type       q_status,
   input  pdpr_pkg::pattern_desc_type       head_desc,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pdpr_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [pdpr_pkg::BASE_W-1:0]      rsp_compare_word,
   output logic                             rsp_last,
   output logic                             rsp_adjusted
);

   logic                              active_ff, active_in;
   logic [pdpr_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   pdpr_pkg::pattern_desc_type        desc_ff, desc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pdpr_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [pdpr_pkg::BASE_W-1:0]       rsp_word_ff, rsp_word_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_adj_ff, rsp_adj_in;
   logic                              out_free;
   logic                              emit;
   logic                              finish;
   logic [pdpr_pkg::BASE_W:0]         sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = active_ff && out_free;
   assign finish   = emit && (slot_ff == pdpr_pkg::SLOT_LAST);
   assign pop      = !q_status.empty && (!active_ff || finish);
   assign sum      = {1'b0, desc_ff.base} + {{pdpr_pkg::BASE_W{1'b0}}, desc_ff.row[slot_ff]};

   always_comb begin
      active_in    = active_ff;
      slot_in      = slot_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_adj_in   = rsp_adj_ff;
      if (emit) begin
         slot_in      = slot_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_slot_in  = slot_ff;
         rsp_word_in  = sum[pdpr_pkg::BASE_W] ? pdpr_pkg::BASE_MAX
                                              : sum[pdpr_pkg::BASE_W-1:0];
         rsp_last_in  = (slot_ff == pdpr_pkg::SLOT_LAST);
         rsp_adj_in   = desc_ff.adjusted;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         active_in = 1'b0;
      end
      if (pop) begin
         active_in = 1'b1;
         slot_in   = '0;
         desc_in   = head_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_adj_ff  <= rsp_adj_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_compare_word = rsp_word_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_adjusted     = rsp_adj_ff;

endmodule

FILE: hdl/pwm_dither_pattern_regulator_core.sv
// ----------------------------------------------------------------------------
// PWM dither pattern regulator core
// Holds a 12-bit setpoint as base and dither level and emits dither patterns.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_opcode, req_value
//  rsp      out        rsp_valid/rsp_stall  rsp_slot, rsp_compare_word,
//                                           rsp_last, rsp_adjusted
//
//  Each word in yields sixteen words out, one a cycle unless rsp_stall holds them,
//  from a registered output stage, so the sustained input rate is set by the
//  pattern expansion in the back end. Setpoint update takes place on the accept
//  edge; a two-entry descriptor queue lets up to two further words be taken
//  while a pattern drains. Reset is synchronous and clears setpoint, queue and
//  output valid. req_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module pwm_dither_pattern_regulator_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [pdpr_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pdpr_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [pdpr_pkg::BASE_W-1:0]      rsp_compare_word,
   output logic                             rsp_last,
   output logic                             rsp_adjusted
);

   pdpr_pkg::queue_status_type  q_status;
   pdpr_pkg::pattern_desc_type  push_desc;
   pdpr_pkg::pattern_desc_type  head_desc;
   logic                        push;
   logic                        pop;

   pdpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .q_status   (q_status),
      .push       (push),
      .push_desc  (push_desc)
   );

   pdpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_status  (q_status)
   );

   pdpr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_desc        (head_desc),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot         (rsp_slot),
      .rsp_compare_word (rsp_compare_word),
      .rsp_last         (rsp_last),
      .rsp_adjusted     (rsp_adjusted)
   );

endmodule

FILE: tb/pwm_dither_pattern_regulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM dither pattern regulator core testbench
// Sends load and measurement words through the request channel. An internal
// setpoint tracker predicts the sixteen compare words that each of them
// produces, and every response word is checked against those predictions in
// order. Both channels are throttled at random in the first two of three phases.
// ----------------------------------------------------------------------------
module pwm_dither_pattern_regulator_core_tb;

   typedef struct packed {
      logic [pdpr_pkg::SLOT_W-1:0] slot;
      logic [pdpr_pkg::BASE_W-1:0] compare_word;
      logic                        last;
      logic                        adjusted;
   } pattern_word_type;

   localparam logic [pdpr_pkg::PATTERN_LEN-1:0] MASK_ROWS [0:15] = '{
      16'h0000, 16'h0001, 16'h0101, 16'h0421,
      16'h1111, 16'h1249, 16'h2525, 16'h2A55,
      16'h5555, 16'hD5AA, 16'hDADA, 16'hEDB6,
      16'hEEEE, 16'hFBDE, 16'hFEFE, 16'hFFFE
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_opcode = 1'b0;
   logic [pdpr_pkg::VALUE_W-1:0]  req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [pdpr_pkg::SLOT_W-1:0]   rsp_slot;
   logic [pdpr_pkg::BASE_W-1:0]   rsp_compare_word;
   logic                          rsp_last;
   logic                          rsp_adjusted;

   logic [pdpr_pkg::VALUE_W-1:0]  target_lvl = '0;
   logic [pdpr_pkg::BASE_W-1:0]   base_lvl = '0;
   logic [pdpr_pkg::DITHER_W-1:0] dither_lvl = '0;
   pattern_word_type              pattern_words_q[$];
   int unsigned                   mismatch_count = 0;
   int unsigned                   req_idle_pct = 0;
   int unsigned                   rsp_idle_pct = 0;

   pwm_dither_pattern_regulator_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot         (rsp_slot),
      .rsp_compare_word (rsp_compare_word),
      .rsp_last         (rsp_last),
      .rsp_adjusted     (rsp_adjusted)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Update the setpoint as the block does, then queue the sixteen words.
   function automatic void predict_pattern(input logic op,
                                           input logic [pdpr_pkg::VALUE_W-1:0] value);
      logic [pdpr_pkg::VALUE_W-1:0]     level;
      logic                             adj;
      logic [pdpr_pkg::PATTERN_LEN-1:0] row;
      logic [pdpr_pkg::BASE_W:0]        sum;
      pattern_word_type                 w;
      adj = 1'b0;
      if (op == pdpr_pkg::OP_LOAD) begin
         level = (value > pdpr_pkg::TARGET_MAX) ? pdpr_pkg::TARGET_MAX : value;
         target_lvl = level;
      end else begin
         level = {base_lvl, dither_lvl};
         if (target_lvl > value) begin
            adj = 1'b1;
            if (base_lvl != pdpr_pkg::BASE_MAX)
               level = level + 1'b1;
         end else if (target_lvl < value) begin
            adj = 1'b1;
            if (level != '0)
               level = level - 1'b1;
         end
      end
      base_lvl   = level[pdpr_pkg::VALUE_W-1:pdpr_pkg::DITHER_W];
      dither_lvl = level[pdpr_pkg::DITHER_W-1:0];
      row = MASK_ROWS[dither_lvl];
      for (int n = 0; n < pdpr_pkg::PATTERN_LEN; n++) begin
         sum = {1'b0, base_lvl} + row[n];
         w.slot         = pdpr_pkg::SLOT_W'(n);
         w.compare_word = (sum > pdpr_pkg::BASE_MAX) ? pdpr_pkg::BASE_MAX
                                                     : sum[pdpr_pkg::BASE_W-1:0];
         w.last         = (n == pdpr_pkg::PATTERN_LEN - 1);
         w.adjusted     = adj;
         pattern_words_q.push_back(w);
      end
   endfunction

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_words
      pattern_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_pattern(req_opcode, req_value);
         if (rsp_valid && !rsp_stall) begin
            if (pattern_words_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual slot %0d word %0d",
                        $time, rsp_slot, rsp_compare_word);
               mismatch_count++;
            end else begin
               want = pattern_words_q.pop_front();
               report_field("slot", want.slot, rsp_slot);
               report_field("compare_word", want.compare_word, rsp_compare_word);
               report_field("last", want.last, rsp_last);
               report_field("adjusted", want.adjusted, rsp_adjusted);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Hold valid across back-to-back words; drop it only for an idle gap.
   task automatic send_word(input pdpr_pkg::opcode_type op,
                            input logic [pdpr_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [pdpr_pkg::VALUE_W-1:0] clamp_value(input int v);
      if (v < 0)
         return '0;
      if (v > 4095)
         return '1;
      return pdpr_pkg::VALUE_W'(v);
   endfunction

   task automatic test_reset_state;
      send_word(pdpr_pkg::OP_MEASURE, 12'h000);
      send_word(pdpr_pkg::OP_MEASURE, 12'h001);
      send_word(pdpr_pkg::OP_MEASURE, 12'hFFF);
   endtask

   task automatic test_load_saturation;
      send_word(pdpr_pkg::OP_LOAD, 12'hFFF);
      send_word(pdpr_pkg::OP_LOAD, 12'hFF1);
      send_word(pdpr_pkg::OP_LOAD, 12'hFF0);
      send_word(pdpr_pkg::OP_LOAD, 12'hAAA);
      send_word(pdpr_pkg::OP_LOAD, 12'h555);
      send_word(pdpr_pkg::OP_LOAD, 12'h000);
   endtask

   task automatic test_step_limits;
      send_word(pdpr_pkg::OP_LOAD, 12'hFFF);
      send_word(pdpr_pkg::OP_MEASURE, 12'h000);
      send_word(pdpr_pkg::OP_MEASURE, 12'hFEF);
      send_word(pdpr_pkg::OP_LOAD, 12'h000);
      send_word(pdpr_pkg::OP_MEASURE, 12'hFFF);
   endtask

   task automatic test_carry_borrow;
      send_word(pdpr_pkg::OP_LOAD, 12'h01F);
      send_word(pdpr_pkg::OP_MEASURE, 12'h000);
      send_word(pdpr_pkg::OP_MEASURE, 12'hFFF);
      send_word(pdpr_pkg::OP_LOAD, 12'hFEF);
      send_word(pdpr_pkg::OP_MEASURE, 12'h000);
      send_word(pdpr_pkg::OP_LOAD, 12'h010);
      send_word(pdpr_pkg::OP_MEASURE, 12'h800);
   endtask

   task automatic test_equal_measure;
      send_word(pdpr_pkg::OP_LOAD, 12'h800);
      send_word(pdpr_pkg::OP_MEASURE, 12'h800);
      send_word(pdpr_pkg::OP_LOAD, 12'hFFF);
      send_word(pdpr_pkg::OP_MEASURE, 12'hFF0);
   endtask

   // Mostly a load followed by a run of measurements biased to one side.
   task automatic test_random_regulation(input int unsigned n_words);
      int unsigned                  sent;
      int unsigned                  pick;
      int unsigned                  run;
      int                           held;
      int                           dir;
      logic [pdpr_pkg::VALUE_W-1:0] aim;
      logic [pdpr_pkg::VALUE_W-1:0] meas;
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_word(pdpr_pkg::opcode_type'($urandom_range(1)),
                      pdpr_pkg::VALUE_W'($urandom_range(4095)));
            sent++;
         end else begin
            pick = $urandom_range(99);
            if (pick < 15)
               aim = pdpr_pkg::VALUE_W'($urandom_range(12'hFFF, 12'hFD0));
            else if (pick < 30)
               aim = pdpr_pkg::VALUE_W'($urandom_range(12'h030, 12'h000));
            else
               aim = pdpr_pkg::VALUE_W'($urandom_range(4095));
            send_word(pdpr_pkg::OP_LOAD, aim);
            sent++;
            held = (aim > pdpr_pkg::TARGET_MAX) ? int'(pdpr_pkg::TARGET_MAX) : int'(aim);
            dir  = $urandom_range(1) ? 1 : -1;
            run  = $urandom_range(40, 2);
            while (run > 0 && sent < n_words) begin
               pick = $urandom_range(99);
               if (pick < 70)
                  meas = clamp_value(held + dir * int'($urandom_range(6, 1)));
               else if (pick < 85)
                  meas = pdpr_pkg::VALUE_W'(held);
               else
                  meas = pdpr_pkg::VALUE_W'($urandom_range(4095));
               send_word(pdpr_pkg::OP_MEASURE, meas);
               sent++;
               run--;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 18;
      rsp_idle_pct = 78;
      test_reset_state;
      test_load_saturation;
      test_step_limits;
      test_carry_borrow;
      test_equal_measure;
      test_random_regulation(85);

      req_idle_pct = 78;
      rsp_idle_pct = 18;
      test_random_regulation(85);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_regulation(85);

      req_valid <= 1'b0;
      while (pattern_words_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && pattern_words_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
